### sv/chbd_pkg.sv
// Types and constants shared by the chunked body decoder modules.
// No dependencies; every other file imports this package.
package chbd_pkg;

	localparam int MAXB_W = 34;
	localparam logic [MAXB_W-1:0] MAXB_RESET = 34'd10737418240;

	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_HT   = 8'h09;
	localparam logic [7:0] CH_VT   = 8'h0B;
	localparam logic [7:0] CH_FF   = 8'h0C;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_TOO_LARGE = 2'd2;

	localparam logic ACT_BYTE  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_payload;
		logic       body_done;
		logic [1:0] status;
	} out_item_t;

	// classified byte, as held in the queue between front and back
	typedef struct packed {
		logic       clear;
		logic [7:0] data;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_ws;
		logic       is_lf;
		logic       is_cr;
		logic       is_semi;
	} class_t;

	typedef enum logic [10:0] {
		PH_SIZE    = 11'b000_0000_0001,
		PH_SIZE_WS = 11'b000_0000_0010,
		PH_EXT     = 11'b000_0000_0100,
		PH_DATA    = 11'b000_0000_1000,
		PH_DEND    = 11'b000_0001_0000,
		PH_DLF     = 11'b000_0010_0000,
		PH_TSTART  = 11'b000_0100_0000,
		PH_TCR     = 11'b000_1000_0000,
		PH_TLINE   = 11'b001_0000_0000,
		PH_DONE    = 11'b010_0000_0000,
		PH_ERR     = 11'b100_0000_0000
	} phase_t;

	// queue state seen by the back part
	typedef struct packed {
		logic   valid;
		class_t item;
	} q_head_t;

endpackage

### sv/chbd_front.sv
// Front part of the chunked body decoder: classifies each raw byte.
// Depends on chbd_pkg.
module chbd_front
	import chbd_pkg::*;
(
	input  in_item_t item,
	output class_t   cls
);

	always_comb begin
		cls = '0;
		cls.clear = (item.action == ACT_CLEAR);
		cls.data  = item.in_byte;
		case (item.in_byte) inside
			[8'h30:8'h39]: begin
				cls.is_hex  = 1'b1;
				cls.hex_val = item.in_byte[3:0];
			end
			[8'h61:8'h66], [8'h41:8'h46]: begin
				cls.is_hex  = 1'b1;
				cls.hex_val = 4'(item.in_byte[3:0] + 4'd9);
			end
			default: cls.is_hex = 1'b0;
		endcase
		cls.is_ws = (item.in_byte == CH_SP) || (item.in_byte == CH_HT) ||
			(item.in_byte == CH_VT) || (item.in_byte == CH_FF) ||
			(item.in_byte == CH_CR);
		cls.is_lf   = (item.in_byte == CH_LF);
		cls.is_cr   = (item.in_byte == CH_CR);
		cls.is_semi = (item.in_byte == CH_SEMI);
	end

endmodule

### sv/chbd_queue.sv
// Two-entry queue between the classifier and the framing engine.
// Depends on chbd_pkg.
module chbd_queue
	import chbd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  class_t  wr_item,
	input  logic    pop,
	output logic    full,
	output q_head_t head
);

	class_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= 2'(count_q + 2'd1);
				2'b01:   count_q <= 2'(count_q - 2'd1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.item  = mem_q[rd_ptr_q];

endmodule

### sv/chbd_back.sv
// Back part of the chunked body decoder: framing state machine, size
// accumulator, body counter and output register. Depends on chbd_pkg.
module chbd_back
	import chbd_pkg::*;
#(
	parameter int SIZE_BITS = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  q_head_t           head,
	output logic              pop,
	input  logic [MAXB_W-1:0] max_body,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_item
);

	phase_t               phase_q, phase_d;
	logic                 have_q, have_d;
	logic [SIZE_BITS-1:0] rem_q, rem_d;
	logic [MAXB_W-1:0]    count_q, count_d;
	logic                 emit;
	out_item_t            res;
	logic                 out_valid_q;
	out_item_t            out_q;
	class_t               c;
	logic [SIZE_BITS-1:0] rem_acc;

	assign c   = head.item;
	assign pop = head.valid && (!out_valid_q || !out_stall);

	// saturate once any of the top four bits is set
	assign rem_acc = (|rem_q[SIZE_BITS-1 -: 4]) ? '1 : {rem_q[SIZE_BITS-5:0], c.hex_val};

	always_comb begin
		phase_d = phase_q;
		have_d  = have_q;
		rem_d   = rem_q;
		count_d = count_q;
		emit    = 1'b0;
		res     = '0;
		if (c.clear) begin
			phase_d = PH_SIZE;
			have_d  = 1'b0;
			rem_d   = '0;
			count_d = '0;
		end else begin
			case (phase_q)
				PH_SIZE: begin
					if (c.is_hex) begin
						have_d = 1'b1;
						rem_d  = rem_acc;
					end else if (c.is_ws) begin
						if (have_q) phase_d = PH_SIZE_WS;
					end else if (c.is_semi && have_q) begin
						phase_d = PH_EXT;
					end else if (c.is_lf && have_q) begin
						have_d  = 1'b0;
						phase_d = (rem_q == '0) ? PH_TSTART : PH_DATA;
					end else begin
						phase_d    = PH_ERR;
						emit       = 1'b1;
						res.status = ST_MALFORMED;
					end
				end
				PH_SIZE_WS: begin
					if (c.is_ws) begin
						phase_d = PH_SIZE_WS;
					end else if (c.is_semi) begin
						phase_d = PH_EXT;
					end else if (c.is_lf) begin
						have_d  = 1'b0;
						phase_d = (rem_q == '0) ? PH_TSTART : PH_DATA;
					end else begin
						phase_d    = PH_ERR;
						emit       = 1'b1;
						res.status = ST_MALFORMED;
					end
				end
				PH_EXT: begin
					if (c.is_lf) begin
						have_d  = 1'b0;
						phase_d = (rem_q == '0) ? PH_TSTART : PH_DATA;
					end
				end
				PH_DATA: begin
					emit = 1'b1;
					if (count_q >= max_body) begin
						phase_d    = PH_ERR;
						res.status = ST_TOO_LARGE;
					end else begin
						count_d        = MAXB_W'(count_q + 1'b1);
						rem_d          = SIZE_BITS'(rem_q - 1'b1);
						res.out_byte   = c.data;
						res.is_payload = 1'b1;
						if (rem_q == SIZE_BITS'(1)) phase_d = PH_DEND;
					end
				end
				PH_DEND: begin
					if (c.is_lf) begin
						phase_d = PH_SIZE;
					end else if (c.is_cr) begin
						phase_d = PH_DLF;
					end else begin
						phase_d    = PH_ERR;
						emit       = 1'b1;
						res.status = ST_MALFORMED;
					end
				end
				PH_DLF: begin
					if (c.is_lf) begin
						phase_d = PH_SIZE;
					end else begin
						phase_d    = PH_ERR;
						emit       = 1'b1;
						res.status = ST_MALFORMED;
					end
				end
				PH_TSTART, PH_TCR: begin
					if (c.is_lf) begin
						phase_d       = PH_DONE;
						emit          = 1'b1;
						res.body_done = 1'b1;
					end else if (c.is_cr && phase_q == PH_TSTART) begin
						phase_d = PH_TCR;
					end else begin
						phase_d = PH_TLINE;
					end
				end
				PH_TLINE: begin
					if (c.is_lf) phase_d = PH_TSTART;
				end
				default: begin
					// done and error: drop bytes until a clear
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIZE;
			have_q      <= 1'b0;
			rem_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				have_q      <= have_d;
				rem_q       <= rem_d;
				count_q     <= count_d;
				out_valid_q <= emit;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

### sv/http_chunked_body_decoder.sv
// Decodes an HTTP/1.1 chunked body one byte per item and passes out data
// bytes, completion and framing or size errors. Depends on chbd_pkg,
// chbd_front, chbd_queue and chbd_back.
//
// Unless the output stalls, the block takes one item per cycle: a classifier
// writes each byte into a two-entry queue and the framing engine removes one
// item per cycle and loads at most one result into the output register. The
// rate is set by the framing engine's single state update per item. Input
// stalls only when the queue is full. A size line's value saturates at
// 2^SIZE_BITS - 1; the body length limit max_body_q resets to 10 GiB; the user
// must write it through cfg_wr_en and cfg_wr_data only while the block is
// idle, which the block itself does not enforce. Action 1 starts a new body and
// gives no result; after completion or an error, bytes are dropped until then.
module http_chunked_body_decoder
	import chbd_pkg::*;
#(
	parameter int SIZE_BITS = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [MAXB_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_item
);

	logic [MAXB_W-1:0] max_body_q;
	class_t            cls;
	logic              push;
	logic              pop;
	logic              full;
	q_head_t           head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q <= MAXB_RESET;
		end else if (cfg_wr_en) begin
			max_body_q <= cfg_wr_data;
		end
	end

	assign in_stall = full;
	assign push     = in_valid && !full;

	chbd_front u_front (
		.item (in_item),
		.cls  (cls)
	);

	chbd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (cls),
		.pop     (pop),
		.full    (full),
		.head    (head)
	);

	chbd_back #(
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.max_body  (max_body_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// a payload byte never carries completion or an error code
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.is_payload |-> out_item.status == ST_OK && !out_item.body_done)
		else $error("payload result with status or done set");

	// the engine only removes items that are in the queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("pop from empty queue");

	// a result not loaded by the last pop must be one held under stall
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(pop) |-> $past(out_valid && out_stall))
		else $error("result appeared without an item");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for http_chunked_body_decoder: chunked bodies go in
// byte by byte and each decoded item is checked against an in-bench decoder.
// Depends on chbd_pkg and the decoder RTL.
module tb_top;
	import chbd_pkg::*;

	localparam int SIZE_BITS = 40;
	localparam logic [63:0] SIZE_MAX = (64'd1 << SIZE_BITS) - 64'd1;
	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE_CYCLES = 8;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [MAXB_W-1:0] cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_item_t          in_item = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_item_t         out_item;

	http_chunked_body_decoder #(.SIZE_BITS(SIZE_BITS)) dut (
		.clk, .arst_n, .cfg_wr_en, .cfg_wr_data,
		.in_valid, .in_stall, .in_item,
		.out_valid, .out_stall, .out_item
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder state as the bench sees it
	phase_t                ph = PH_SIZE;
	bit                    have_dig = 1'b0;
	logic [SIZE_BITS-1:0]  remaining = '0;
	logic [34:0]           body_cnt = '0;
	logic [MAXB_W-1:0]     body_limit = MAXB_RESET;
	int unsigned           live_cnt = 0;

	out_item_t decoded_q[$];
	in_item_t  stim_q[$];
	int        fail_cnt = 0;
	int        quiet_cycles = 0;
	bit        tx_idle_en = 1'b1;
	logic      rx_idle_en = 1'b1;
	logic [3:0] hold_token = '0;
	logic [3:0] hold_seen = '0;
	int        hold_left = 0;
	out_item_t want;

	function automatic bit is_hex(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [3:0] hex_nibble(logic [7:0] c);
		logic [7:0] v;
		if (c <= "9") v = c - "0";
		else if (c >= "a") v = c - "a" + 8'd10;
		else v = c - "A" + 8'd10;
		return v[3:0];
	endfunction

	function automatic bit is_space(logic [7:0] c);
		return c == CH_SP || c == CH_HT || c == CH_VT || c == CH_FF || c == CH_CR;
	endfunction

	task automatic end_size_line;
		have_dig = 1'b0;
		ph = (remaining == '0) ? PH_TSTART : PH_DATA;
	endtask

	// Advance the decoder by one item and return the result it causes, if any.
	task automatic chunk_decode(input in_item_t it, output bit has, output out_item_t res);
		logic [7:0]  c;
		logic [63:0] acc;
		logic [63:0] nxt;
		logic [3:0]  nib;
		bit          bad;
		c = it.in_byte;
		has = 1'b0;
		res = '0;
		bad = 1'b0;
		if (it.action == ACT_CLEAR) begin
			ph = PH_SIZE;
			have_dig = 1'b0;
			remaining = '0;
			body_cnt = '0;
			return;
		end
		if (ph != PH_DONE && ph != PH_ERR) live_cnt++;
		case (ph)
		PH_SIZE: begin
			if (is_hex(c)) begin
				nib = hex_nibble(c);
				have_dig = 1'b1;
				acc = {{(64-SIZE_BITS){1'b0}}, remaining};
				// saturate instead of wrapping
				if (acc > ((SIZE_MAX - {60'd0, nib}) >> 4)) begin
					remaining = SIZE_MAX[SIZE_BITS-1:0];
				end else begin
					nxt = (acc << 4) + {60'd0, nib};
					remaining = nxt[SIZE_BITS-1:0];
				end
			end else if (is_space(c)) begin
				if (have_dig) ph = PH_SIZE_WS;
			end else if (c == CH_SEMI && have_dig) begin
				ph = PH_EXT;
			end else if (c == CH_LF && have_dig) begin
				end_size_line();
			end else begin
				bad = 1'b1;
			end
		end
		PH_SIZE_WS: begin
			if (c == CH_SEMI) ph = PH_EXT;
			else if (c == CH_LF) end_size_line();
			else if (!is_space(c)) bad = 1'b1;
		end
		PH_EXT: begin
			if (c == CH_LF) end_size_line();
		end
		PH_DATA: begin
			has = 1'b1;
			if (body_cnt >= {1'b0, body_limit}) begin
				ph = PH_ERR;
				res.status = ST_TOO_LARGE;
			end else begin
				body_cnt = body_cnt + 35'd1;
				remaining = remaining - 1'b1;
				if (remaining == '0) ph = PH_DEND;
				res.out_byte = c;
				res.is_payload = 1'b1;
				res.status = ST_OK;
			end
		end
		PH_DEND: begin
			if (c == CH_LF) ph = PH_SIZE;
			else if (c == CH_CR) ph = PH_DLF;
			else bad = 1'b1;
		end
		PH_DLF: begin
			if (c == CH_LF) ph = PH_SIZE;
			else bad = 1'b1;
		end
		PH_TSTART, PH_TCR: begin
			if (c == CH_LF) begin
				ph = PH_DONE;
				has = 1'b1;
				res.body_done = 1'b1;
			end else begin
				ph = (c == CH_CR && ph == PH_TSTART) ? PH_TCR : PH_TLINE;
			end
		end
		PH_TLINE: begin
			if (c == CH_LF) ph = PH_TSTART;
		end
		default: ;
		endcase
		if (bad) begin
			ph = PH_ERR;
			has = 1'b1;
			res.status = ST_MALFORMED;
		end
	endtask

	// ---------------- sender ----------------

	task automatic send_item(input in_item_t it);
		bit        has;
		out_item_t res;
		if (tx_idle_en && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		chunk_decode(it, has, res);
		if (has) decoded_q.push_back(res);
	endtask

	task automatic send_all;
		while (stim_q.size() != 0) send_item(stim_q.pop_front());
	endtask

	task automatic wait_drained;
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_body_limit(input logic [MAXB_W-1:0] v);
		wait_drained();
		// let trailing framing bytes leave the pipeline
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		body_limit = v;
	endtask

	// ---------------- stimulus building ----------------

	function automatic logic [7:0] rand_byte();
		logic [31:0] r;
		r = $urandom;
		return r[7:0];
	endfunction

	function automatic logic [7:0] rand_not_lf();
		logic [7:0] b;
		do b = rand_byte(); while (b == CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] ws_byte();
		case ($urandom_range(0, 4))
		0: return CH_SP;
		1: return CH_HT;
		2: return CH_VT;
		3: return CH_FF;
		default: return CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n, bit up);
		if (n < 4'd10) return 8'h30 + {4'd0, n};
		return (up ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
	endfunction

	// bias toward bytes that mean something to the framing
	function automatic logic [7:0] frame_byte();
		logic [3:0] n;
		n = 4'(rand_byte());
		case ($urandom_range(0, 6))
		0: return CH_CR;
		1: return CH_LF;
		2: return ws_byte();
		3: return hex_char(n, 1'($urandom_range(0, 1)));
		4: return CH_SEMI;
		default: return rand_byte();
		endcase
	endfunction

	task automatic push_byte(input logic [7:0] b);
		stim_q.push_back('{action: ACT_BYTE, in_byte: b});
	endtask

	task automatic push_clear(input logic [7:0] b);
		stim_q.push_back('{action: ACT_CLEAR, in_byte: b});
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endtask

	task automatic push_line_end;
		if ($urandom_range(0, 1)) push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	task automatic push_size_line(input logic [63:0] chunk_len);
		int unsigned nib;
		bit up;
		up = 1'($urandom_range(0, 1));
		repeat ($urandom_range(0, 2)) push_byte(ws_byte());
		repeat ($urandom_range(0, 1)) push_byte("0");
		nib = 1;
		while (nib < 16 && (chunk_len >> (4 * nib)) != 0) nib++;
		for (int i = nib - 1; i >= 0; i--) push_byte(hex_char(chunk_len[4*i +: 4], up));
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_byte(ws_byte());
		if ($urandom_range(0, 3) == 0) begin
			push_byte(CH_SEMI);
			repeat ($urandom_range(0, 3)) push_byte(rand_not_lf());
		end
		push_line_end();
	endtask

	task automatic push_good_body(input bit huge_ok);
		int unsigned r;
		int unsigned len;
		logic [63:0] big;
		push_clear(rand_byte());
		repeat ($urandom_range(0, 3)) begin
			r = $urandom_range(0, 99);
			if (huge_ok && r >= 97) begin
				// chunk that never ends; the next body's clear aborts it
				big = {$urandom, $urandom} | 64'h1_0000_0000;
				push_size_line(big);
				repeat ($urandom_range(1, 8)) push_byte(rand_byte());
				return;
			end
			len = (r < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
			push_size_line(64'(len));
			repeat (len) push_byte(rand_byte());
			push_line_end();
		end
		push_size_line(64'd0);
		repeat ($urandom_range(0, 2)) begin
			if ($urandom_range(0, 3) == 0) push_byte(CH_CR);
			repeat ($urandom_range(1, 3)) push_byte(rand_not_lf());
			push_line_end();
		end
		push_line_end();
	endtask

	task automatic corrupt_body;
		int unsigned pos;
		in_item_t    tmp;
		pos = $urandom_range(1, stim_q.size() - 1);
		case ($urandom_range(0, 3))
		0: begin
			tmp = stim_q[pos];
			tmp.in_byte = frame_byte();
			stim_q[pos] = tmp;
		end
		1: stim_q.insert(pos, '{action: ACT_BYTE, in_byte: frame_byte()});
		2: stim_q.insert(pos, '{action: ACT_CLEAR, in_byte: rand_byte()});
		default: stim_q.delete(pos);
		endcase
	endtask

	task automatic run_bodies(input int unsigned n, input bit huge_ok);
		int unsigned target;
		int unsigned r;
		target = live_cnt + n;
		while (live_cnt < target) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				push_clear(rand_byte());
				repeat ($urandom_range(3, 20)) push_byte(frame_byte());
			end else begin
				push_good_body(huge_ok);
				if (r < 30) corrupt_body();
			end
			send_all();
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_directed;
		// whitespace after the size digit, extension, CRLF after data, CR-led trailer
		// line, then a byte after completion that must be dropped
		push_clear(8'hFF);
		push_text("1");
		push_byte(CH_FF);
		push_text(";\n");
		push_byte(8'hFF);
		push_byte(CH_CR);
		push_text("\n0\n");
		push_byte(CH_CR);
		push_text("x\n");
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_byte(8'h00);
		// empty size line, both ways
		push_clear(8'h00);
		push_text(";");
		push_clear(8'h00);
		push_text("\n");
		// hex prefix and digit after trailing whitespace
		push_clear(8'h00);
		push_text("0x");
		push_clear(8'h00);
		push_text("1 2");
		// CR after data not followed by LF
		push_clear(8'h00);
		push_text("1\nA");
		push_byte(CH_CR);
		push_text("B");
		send_all();
	endtask

	task automatic test_random_bodies;
		run_bodies(100, 1'b0);
	endtask

	task automatic test_body_limits;
		set_body_limit('0);
		push_clear(rand_byte());
		push_text("1\n");
		push_byte(8'h5A);
		send_all();
		// saturated size, stopped by the limit
		set_body_limit(MAXB_W'(2));
		push_clear(rand_byte());
		repeat (18) push_text("f");
		push_byte(CH_LF);
		repeat (3) push_byte(rand_byte());
		send_all();
		repeat (3) begin
			set_body_limit(MAXB_W'($urandom_range(1, 30)));
			run_bodies(50, 1'b1);
		end
		set_body_limit('1);
		run_bodies(40, 1'b1);
	endtask

	task automatic test_no_idle;
		tx_idle_en = 1'b0;
		rx_idle_en <= 1'b0;
		run_bodies(60, 1'b0);
		tx_idle_en = 1'b1;
		rx_idle_en <= 1'b1;
	endtask

	task automatic test_backpressure;
		tx_idle_en = 1'b0;
		rx_idle_en <= 1'b0;
		hold_token <= hold_token + 4'd1;
		push_clear(rand_byte());
		push_size_line(64'd48);
		repeat (48) push_byte(rand_byte());
		push_line_end();
		push_size_line(64'd0);
		push_line_end();
		send_all();
		run_bodies(40, 1'b0);
		tx_idle_en = 1'b1;
		rx_idle_en <= 1'b1;
	endtask

	task automatic test_drain_pause;
		int unsigned half;
		repeat (3) begin
			push_good_body(1'b0);
			half = stim_q.size() / 2;
			repeat (half) send_item(stim_q.pop_front());
			wait_drained();
			send_all();
		end
	endtask

	// ---------------- receiver and checker ----------------

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
			fail_cnt++;
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				$error("result with nothing expected: %p", out_item);
				fail_cnt++;
			end else begin
				want = decoded_q.pop_front();
				check_field("out_byte", want.out_byte, out_item.out_byte);
				check_field("is_payload", {7'd0, want.is_payload}, {7'd0, out_item.is_payload});
				check_field("body_done", {7'd0, want.body_done}, {7'd0, out_item.body_done});
				check_field("status", {6'd0, want.status}, {6'd0, out_item.status});
			end
		end
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= rx_idle_en && ($urandom_range(0, 99) < 10);
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_bodies();
		test_body_limits();
		test_no_idle();
		test_backpressure();
		test_drain_pause();
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_cnt == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

### filelist.f
sv/chbd_pkg.sv
sv/chbd_front.sv
sv/chbd_queue.sv
sv/chbd_back.sv
sv/http_chunked_body_decoder.sv
tb/sv/tb_top.sv
